### rtl/glae_pkg.sv
// ----------------------------------------------------------------------------
// glae_pkg
// Shared types and constants of the grid luma auto-exposure block.
// ----------------------------------------------------------------------------
`default_nettype none

package glae_pkg;

    localparam int SAMPLE_STEP_DEF = 50;

    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 13;
    localparam int POS_W      = 12;
    localparam int SUM_W      = 21;
    localparam int CNT_W      = 14;
    localparam int LUMA_W     = 8;
    localparam int EXP_W      = 17;
    localparam int GAIN_W     = 18;
    localparam int THR_W      = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int QDEPTH     = 2;

    // serial divider: dividend is exposure shifted up by the Q16 point
    localparam int DIVD_W = EXP_W + 16;
    localparam int DIVS_W = GAIN_W;

    localparam logic [SIZE_W-1:0] FRAME_MAX = SIZE_W'(4096);

    // luma weights, Q16
    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;

    localparam logic [EXP_W-1:0] EXP_MAX   = '1;
    localparam logic [EXP_W-1:0] EXP_RESET = EXP_W'(3200);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHT_LOWER = 3'd0,
        REG_BRIGHT_UPPER = 3'd1,
        REG_GAIN_STEP    = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_FRAME_HEIGHT = 3'd4,
        REG_EXP_FLOOR    = 3'd5,
        REG_EXP_CEILING  = 3'd6
    } cfg_reg_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 2'd0,
        KIND_RAISED  = 2'd1,
        KIND_LOWERED = 2'd2
    } adjust_kind_t;

    typedef struct packed {
        logic [SUM_W-1:0] luma_sum;
        logic [CNT_W-1:0] sample_total;
    } job_t;

    typedef struct packed {
        logic [LUMA_W-1:0] bright_lower;
        logic [LUMA_W-1:0] bright_upper;
        logic [GAIN_W-1:0] gain_step;
        logic [THR_W-1:0]  exp_floor;
        logic [THR_W-1:0]  exp_ceiling;
    } exp_cfg_t;

    typedef struct packed {
        logic full;
        logic almost_full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

### rtl/grid_luma_auto_exposure.sv
// ----------------------------------------------------------------------------
// grid_luma_auto_exposure
// Grid-sampled average luma and multiplicative auto-exposure step.
// ----------------------------------------------------------------------------
// Takes one BGR pixel per clock in raster order; every SAMPLE_STEP-th row and
// column feeds a luma sum. On a frame's last pixel the sum and sample count go
// into a two-entry queue, and the back end works out the average and the new
// exposure with a shared bit-serial divider (one quotient bit per clock) and
// one 17x18 multiplier. Frame-end work runs the average division and a decide
// step, then a multiply when the exposure is raised or a second division when
// it is lowered, then the result step, which may wait on m_tready. The pixel
// input takes one beat per clock except when the queue cannot take another
// frame end (two frames queued, or one queued and another just closing), which
// only frames shorter than the back-end time or a stalled result channel can
// cause. One result beat per frame, valid the clock after the back end ends.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_luma_auto_exposure
    import glae_pkg::*;
#(
    parameter int SAMPLE_STEP = SAMPLE_STEP_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,   // pixel_blue, pixel_green, pixel_red

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // average_luma, new_exposure, zero pad
    output logic [KIND_W-1:0]          m_tuser,   // adjust_kind

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [LUMA_W-1:0]  bright_lower_reg;
    logic [LUMA_W-1:0]  bright_upper_reg;
    logic [GAIN_W-1:0]  gain_step_reg;
    logic [SIZE_W-1:0]  frame_width_reg;
    logic [SIZE_W-1:0]  frame_height_reg;
    logic [THR_W-1:0]   exp_floor_reg;
    logic [THR_W-1:0]   exp_ceiling_reg;

    exp_cfg_t           exp_cfg;
    q_status_t          q_status;
    logic               push, pop;
    job_t               push_job, pop_job;
    logic [LUMA_W-1:0]  average_luma;
    logic [EXP_W-1:0]   new_exposure;
    logic               cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_lower_reg <= LUMA_W'(100);
            bright_upper_reg <= LUMA_W'(120);
            gain_step_reg    <= GAIN_W'(68813);
            frame_width_reg  <= SIZE_W'(1280);
            frame_height_reg <= SIZE_W'(1024);
            exp_floor_reg    <= THR_W'(200);
            exp_ceiling_reg  <= THR_W'(40000);
        end else if (cfg_write) begin
            case (cfg_reg_t'(cfg_index))
                REG_BRIGHT_LOWER: bright_lower_reg <= cfg_data[LUMA_W-1:0];
                REG_BRIGHT_UPPER: bright_upper_reg <= cfg_data[LUMA_W-1:0];
                REG_GAIN_STEP:    gain_step_reg    <= cfg_data[GAIN_W-1:0];
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[SIZE_W-1:0];
                REG_EXP_FLOOR:    exp_floor_reg    <= cfg_data[THR_W-1:0];
                REG_EXP_CEILING:  exp_ceiling_reg  <= cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign exp_cfg.bright_lower = bright_lower_reg;
    assign exp_cfg.bright_upper = bright_upper_reg;
    assign exp_cfg.gain_step    = gain_step_reg;
    assign exp_cfg.exp_floor    = exp_floor_reg;
    assign exp_cfg.exp_ceiling  = exp_ceiling_reg;

    glae_front #(
        .SAMPLE_STEP (SAMPLE_STEP)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .pixel_blue   (s_tdata[7:0]),
        .pixel_green  (s_tdata[15:8]),
        .pixel_red    (s_tdata[23:16]),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .q_status     (q_status),
        .push         (push),
        .push_job     (push_job)
    );

    glae_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    glae_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (exp_cfg),
        .q_status     (q_status),
        .pop_job      (pop_job),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .average_luma (average_luma),
        .new_exposure (new_exposure),
        .adjust_kind  (m_tuser)
    );

    assign m_tdata = {7'd0, new_exposure, average_luma};

endmodule

`default_nettype wire

### rtl/glae_fifo.sv
// ----------------------------------------------------------------------------
// glae_fifo
// Short queue of frame statistics between the pixel front end and the
// exposure back end.
// ----------------------------------------------------------------------------
`default_nettype none

module glae_fifo
    import glae_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  job_t           push_job,
    input  wire logic      pop,
    output job_t           pop_job,
    output q_status_t      status
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    job_t               mem_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QDEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_QW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign pop_job            = mem_reg[rd_ptr_reg];
    assign status.full        = (count_reg == CNT_QW'(QDEPTH));
    assign status.almost_full = (count_reg >= CNT_QW'(QDEPTH - 1));
    assign status.empty       = (count_reg == '0);

endmodule

`default_nettype wire

### rtl/glae_front.sv
// ----------------------------------------------------------------------------
// glae_front
// Pixel front end: raster counters, grid sampling, luma and accumulation.
// Hands the frame's sum and sample count to the queue on the last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module glae_front
    import glae_pkg::*;
#(
    parameter int SAMPLE_STEP = SAMPLE_STEP_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [PIX_W-1:0]  pixel_blue,
    input  wire logic [PIX_W-1:0]  pixel_green,
    input  wire logic [PIX_W-1:0]  pixel_red,
    input  wire logic [SIZE_W-1:0] frame_width,
    input  wire logic [SIZE_W-1:0] frame_height,
    input  q_status_t              q_status,
    output logic                   push,
    output job_t                   push_job
);

    localparam int STEP_W = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SAMPLE_STEP - 1);

    logic                 accept;
    logic [SIZE_W-1:0]    width_eff, height_eff;
    logic                 row_end, frame_end, sample_here;

    logic [POS_W-1:0]     col_pos_reg, col_pos_next;
    logic [POS_W-1:0]     row_pos_reg, row_pos_next;
    logic [STEP_W-1:0]    col_mod_reg, col_mod_next;
    logic [STEP_W-1:0]    row_mod_reg, row_mod_next;

    // product stage
    logic                 st_valid_reg;
    logic                 st_sample_reg;
    logic                 st_last_reg;
    logic [23:0]          prod_r_reg, prod_g_reg, prod_b_reg;

    logic [23:0]          luma_full;
    logic [LUMA_W-1:0]    luma;
    logic [SUM_W:0]       sum_ext;
    logic [SUM_W-1:0]     sum_add;
    logic [CNT_W-1:0]     cnt_add;
    logic [SUM_W-1:0]     luma_sum_reg, luma_sum_next;
    logic [CNT_W-1:0]     sample_total_reg, sample_total_next;

    always_comb begin
        width_eff = frame_width;
        if (frame_width == '0) begin
            width_eff = SIZE_W'(1);
        end else if (frame_width > FRAME_MAX) begin
            width_eff = FRAME_MAX;
        end
        height_eff = frame_height;
        if (frame_height == '0) begin
            height_eff = SIZE_W'(1);
        end else if (frame_height > FRAME_MAX) begin
            height_eff = FRAME_MAX;
        end
    end

    // room for a pending frame end plus this beat's possible frame end
    assign s_tready = !q_status.full && !(q_status.almost_full && st_valid_reg && st_last_reg);
    assign accept   = s_tvalid && s_tready;

    assign row_end     = (({1'b0, col_pos_reg} + SIZE_W'(1)) >= width_eff);
    assign frame_end   = row_end && (({1'b0, row_pos_reg} + SIZE_W'(1)) >= height_eff);
    assign sample_here = (col_mod_reg == '0) && (row_mod_reg == '0);

    always_comb begin
        col_pos_next = col_pos_reg;
        row_pos_next = row_pos_reg;
        col_mod_next = col_mod_reg;
        row_mod_next = row_mod_reg;
        if (accept) begin
            if (!row_end) begin
                col_pos_next = col_pos_reg + POS_W'(1);
                col_mod_next = (col_mod_reg == STEP_LAST) ? '0 : col_mod_reg + STEP_W'(1);
            end else begin
                col_pos_next = '0;
                col_mod_next = '0;
                if (!frame_end) begin
                    row_pos_next = row_pos_reg + POS_W'(1);
                    row_mod_next = (row_mod_reg == STEP_LAST) ? '0 : row_mod_reg + STEP_W'(1);
                end else begin
                    row_pos_next = '0;
                    row_mod_next = '0;
                end
            end
        end
    end

    assign luma_full = prod_r_reg + prod_g_reg + prod_b_reg;
    assign luma      = luma_full[23:16];
    assign sum_ext   = {1'b0, luma_sum_reg} + (SUM_W + 1)'(luma);

    always_comb begin
        sum_add = luma_sum_reg;
        cnt_add = sample_total_reg;
        if (st_sample_reg) begin
            sum_add = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            if (sample_total_reg != '1) begin
                cnt_add = sample_total_reg + CNT_W'(1);
            end
        end
        luma_sum_next     = luma_sum_reg;
        sample_total_next = sample_total_reg;
        if (st_valid_reg) begin
            if (st_last_reg) begin
                luma_sum_next     = '0;
                sample_total_next = '0;
            end else begin
                luma_sum_next     = sum_add;
                sample_total_next = cnt_add;
            end
        end
    end

    assign push                  = st_valid_reg && st_last_reg;
    assign push_job.luma_sum     = sum_add;
    assign push_job.sample_total = cnt_add;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg      <= '0;
            row_pos_reg      <= '0;
            col_mod_reg      <= '0;
            row_mod_reg      <= '0;
            st_valid_reg     <= 1'b0;
            st_sample_reg    <= 1'b0;
            st_last_reg      <= 1'b0;
            luma_sum_reg     <= '0;
            sample_total_reg <= '0;
        end else begin
            col_pos_reg      <= col_pos_next;
            row_pos_reg      <= row_pos_next;
            col_mod_reg      <= col_mod_next;
            row_mod_reg      <= row_mod_next;
            st_valid_reg     <= accept;
            st_sample_reg    <= accept && sample_here;
            st_last_reg      <= accept && frame_end;
            luma_sum_reg     <= luma_sum_next;
            sample_total_reg <= sample_total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prod_r_reg <= 24'(pixel_red) * 24'(COEF_R);
            prod_g_reg <= 24'(pixel_green) * 24'(COEF_G);
            prod_b_reg <= 24'(pixel_blue) * 24'(COEF_B);
        end
    end

endmodule

`default_nettype wire

### rtl/glae_div.sv
// ----------------------------------------------------------------------------
// glae_div
// Restoring divider, one quotient bit per clock. Shared by the frame average
// and the exposure step-down.
// ----------------------------------------------------------------------------
`default_nettype none

module glae_div
    import glae_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIVD_W-1:0] dividend,
    input  wire logic [DIVS_W-1:0] divisor,
    output logic                   done,
    output logic [DIVD_W-1:0]      quotient
);

    localparam int ITER_W = $clog2(DIVD_W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [DIVD_W-1:0]   quo_reg, quo_next;
    logic [DIVS_W-1:0]   rem_reg, rem_next;
    logic [DIVS_W-1:0]   dvs_reg, dvs_next;
    logic [DIVS_W:0]     rem_shift;
    logic [DIVS_W:0]     rem_sub;
    logic                fits;

    assign rem_shift = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            iter_next = ITER_W'(DIVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[DIVD_W-2:0], fits};
            rem_next  = fits ? rem_sub[DIVS_W-1:0] : rem_shift[DIVS_W-1:0];
            iter_next = iter_reg - ITER_W'(1);
            if (iter_reg == ITER_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/glae_back.sv
// ----------------------------------------------------------------------------
// glae_back
// Exposure back end: frame average, exposure step up or down, result
// register. Holds the running exposure value.
// ----------------------------------------------------------------------------
`default_nettype none

module glae_back
    import glae_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  exp_cfg_t              cfg,
    input  q_status_t             q_status,
    input  job_t                  pop_job,
    output logic                  pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [LUMA_W-1:0]     average_luma,
    output logic [EXP_W-1:0]      new_exposure,
    output logic [KIND_W-1:0]     adjust_kind
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_DECIDE,
        ST_MUL,
        ST_EXP,
        ST_OUT
    } state_t;

    localparam int PROD_W = EXP_W + GAIN_W;

    state_t               state_reg, state_next;
    logic [EXP_W-1:0]     exposure_reg, exposure_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [LUMA_W-1:0]    avg_reg, avg_next;
    logic [EXP_W-1:0]     res_exp_reg, res_exp_next;
    adjust_kind_t         res_kind_reg, res_kind_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 m_valid_reg, m_valid_next;
    logic [LUMA_W-1:0]    m_avg_reg, m_avg_next;
    logic [EXP_W-1:0]     m_exp_reg, m_exp_next;
    logic [KIND_W-1:0]    m_kind_reg, m_kind_next;

    logic                 div_start;
    logic [DIVD_W-1:0]    div_dividend;
    logic [DIVS_W-1:0]    div_divisor;
    logic                 div_done;
    logic [DIVD_W-1:0]    div_quotient;
    logic                 in_window;
    logic                 out_free;

    glae_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign in_window = ({1'b0, cfg.exp_floor} < exposure_reg)
                    && (exposure_reg < {1'b0, cfg.exp_ceiling});
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        exposure_next = exposure_reg;
        count_next    = count_reg;
        avg_next      = avg_reg;
        res_exp_next  = res_exp_reg;
        res_kind_next = res_kind_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_avg_next    = m_avg_reg;
        m_exp_next    = m_exp_reg;
        m_kind_next   = m_kind_reg;
        pop           = 1'b0;
        div_start     = 1'b0;
        div_dividend  = DIVD_W'(pop_job.luma_sum);
        div_divisor   = DIVS_W'(pop_job.sample_total);

        case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    pop        = 1'b1;
                    div_start  = 1'b1;
                    count_next = pop_job.sample_total;
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                if (div_done) begin
                    if (count_reg == '0) begin
                        avg_next = '0;
                    end else if (div_quotient[DIVD_W-1:LUMA_W] != '0) begin
                        avg_next = '1;
                    end else begin
                        avg_next = div_quotient[LUMA_W-1:0];
                    end
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_exp_next  = exposure_reg;
                res_kind_next = KIND_NONE;
                state_next    = ST_OUT;
                if (in_window) begin
                    if (avg_reg < cfg.bright_lower) begin
                        prod_next  = PROD_W'(exposure_reg) * PROD_W'(cfg.gain_step);
                        state_next = ST_MUL;
                    end else if (avg_reg > cfg.bright_upper) begin
                        res_kind_next = KIND_LOWERED;
                        if (cfg.gain_step == '0) begin
                            res_exp_next = EXP_MAX;
                        end else begin
                            div_start    = 1'b1;
                            div_dividend = {exposure_reg, 16'h0000};
                            div_divisor  = cfg.gain_step;
                            state_next   = ST_EXP;
                        end
                    end
                end
            end
            ST_MUL: begin
                res_kind_next = KIND_RAISED;
                res_exp_next  = (prod_reg[PROD_W-1:EXP_W+16] != '0)
                              ? EXP_MAX : prod_reg[EXP_W+15:16];
                state_next    = ST_OUT;
            end
            ST_EXP: begin
                if (div_done) begin
                    res_exp_next = (div_quotient[DIVD_W-1:EXP_W] != '0)
                                 ? EXP_MAX : div_quotient[EXP_W-1:0];
                    state_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_avg_next    = avg_reg;
                    m_exp_next    = res_exp_reg;
                    m_kind_next   = res_kind_reg;
                    exposure_next = res_exp_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            exposure_reg <= EXP_RESET;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            exposure_reg <= exposure_next;
            m_valid_reg  <= m_valid_next;
        end
        count_reg    <= count_next;
        avg_reg      <= avg_next;
        res_exp_reg  <= res_exp_next;
        res_kind_reg <= res_kind_next;
        prod_reg     <= prod_next;
        m_avg_reg    <= m_avg_next;
        m_exp_reg    <= m_exp_next;
        m_kind_reg   <= m_kind_next;
    end

    assign m_tvalid     = m_valid_reg;
    assign average_luma = m_avg_reg;
    assign new_exposure = m_exp_reg;
    assign adjust_kind  = m_kind_reg;

endmodule

`default_nettype wire
